>>> rtl/kscc_pkg.sv
// Shared types, constants and helpers for the keyword substitution cipher.
package kscc_pkg;

	localparam int unsigned AlphaN = 26;
	localparam int unsigned IdxW   = 5;

	localparam logic [7:0] LowerA  = 8'd97;
	localparam logic [7:0] LowerZ  = 8'd122;
	localparam logic [7:0] UpperA  = 8'd65;
	localparam logic [7:0] UpperZ  = 8'd90;
	localparam logic [7:0] CaseGap = 8'd32;

	typedef logic [IdxW-1:0]   idx_t;
	typedef logic [AlphaN-1:0] mask_t;

	typedef enum logic [1:0] {
		MODE_KEY    = 2'd0,
		MODE_FINISH = 2'd1,
		MODE_ENC    = 2'd2,
		MODE_DEC    = 2'd3
	} mode_t;

	typedef struct packed {
		logic       en;
		mode_t      mode;
		logic [7:0] in_char;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       was_letter;
	} res_t;

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= LowerA) && (c <= LowerZ);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= UpperA) && (c <= UpperZ);
	endfunction

endpackage

>>> rtl/kscc_if.sv
// Valid/ready channel interfaces for input items and result items.
interface kscc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] in_char;

	modport source (output valid, output mode, output in_char, input ready);
	modport sink (input valid, input mode, input in_char, output ready);
endinterface

interface kscc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       was_letter;

	modport source (output valid, output out_char, output was_letter, input ready);
	modport sink (input valid, input out_char, input was_letter, output ready);
endinterface

>>> rtl/kscc_table.sv
// Substitution tables: keyword fill, table finish and forward/inverse lookup.
module kscc_table (
	input  logic            clk,
	input  logic            arst_n,
	input  kscc_pkg::cmd_t  cmd,
	output kscc_pkg::res_t  res
);

	kscc_pkg::idx_t  fwd_q [kscc_pkg::AlphaN];
	kscc_pkg::idx_t  inv_q [kscc_pkg::AlphaN];
	kscc_pkg::mask_t used_q;
	kscc_pkg::idx_t  fill_q;
	logic            open_q;

	// Lookup path.
	logic           lower;
	logic           upper;
	kscc_pkg::idx_t look_idx;
	kscc_pkg::idx_t look_val;

	always_comb begin
		lower    = kscc_pkg::is_lower(cmd.in_char);
		upper    = kscc_pkg::is_upper(cmd.in_char);
		look_idx = lower ? kscc_pkg::idx_t'(cmd.in_char - kscc_pkg::LowerA)
		                 : kscc_pkg::idx_t'(cmd.in_char - kscc_pkg::UpperA);
		look_val = '0;
		if ((lower || upper) && (look_idx < kscc_pkg::idx_t'(kscc_pkg::AlphaN))) begin
			look_val = (cmd.mode == kscc_pkg::MODE_DEC) ? inv_q[look_idx] : fwd_q[look_idx];
		end
		res.was_letter = lower || upper;
		if (lower) begin
			res.out_char = kscc_pkg::LowerA + {3'b000, look_val};
		end else if (upper) begin
			res.out_char = kscc_pkg::UpperA + {3'b000, look_val};
		end else begin
			res.out_char = cmd.in_char;
		end
	end

	// Keyword path. A keyword beat with no open table starts a fresh one.
	logic [7:0]      key_char;
	logic            key_letter;
	kscc_pkg::idx_t  key_idx;
	kscc_pkg::mask_t used_base;
	kscc_pkg::idx_t  fill_base;
	logic            key_new;

	always_comb begin
		key_char   = upper ? (cmd.in_char + kscc_pkg::CaseGap) : cmd.in_char;
		key_letter = kscc_pkg::is_lower(key_char);
		key_idx    = kscc_pkg::idx_t'(key_char - kscc_pkg::LowerA);
		used_base  = open_q ? used_q : '0;
		fill_base  = open_q ? fill_q : '0;
		key_new    = key_letter && (fill_base < kscc_pkg::idx_t'(kscc_pkg::AlphaN))
		             && !used_base[key_idx];
	end

	// Finish path. Each unused letter lands after the filled slots, ranked by
	// how many unused letters lie below it.
	kscc_pkg::idx_t rank    [kscc_pkg::AlphaN];
	kscc_pkg::idx_t pos     [kscc_pkg::AlphaN];
	kscc_pkg::idx_t fin_fwd [kscc_pkg::AlphaN];
	kscc_pkg::idx_t fin_inv [kscc_pkg::AlphaN];
	kscc_pkg::idx_t unused_n;

	always_comb begin
		unused_n = kscc_pkg::idx_t'($countones(~used_q));
		for (int i = 0; i < kscc_pkg::AlphaN; i++) begin
			rank[i] = kscc_pkg::idx_t'($countones(~used_q
			          & ((kscc_pkg::mask_t'(1) << i) - kscc_pkg::mask_t'(1))));
			pos[i]  = kscc_pkg::idx_t'(fill_q + rank[i]);
			fin_inv[i] = (!used_q[i] && (pos[i] < kscc_pkg::idx_t'(kscc_pkg::AlphaN)))
			             ? pos[i] : inv_q[i];
		end
		for (int k = 0; k < kscc_pkg::AlphaN; k++) begin
			fin_fwd[k] = fwd_q[k];
			for (int i = 0; i < kscc_pkg::AlphaN; i++) begin
				if (!used_q[i] && (pos[i] == kscc_pkg::idx_t'(k))) begin
					fin_fwd[k] = kscc_pkg::idx_t'(i);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kscc_pkg::AlphaN; i++) begin
				fwd_q[i] <= kscc_pkg::idx_t'(i);
				inv_q[i] <= kscc_pkg::idx_t'(i);
			end
			used_q <= '0;
			fill_q <= '0;
			open_q <= 1'b0;
		end else if (cmd.en) begin
			unique case (cmd.mode)
				kscc_pkg::MODE_KEY: begin
					open_q <= 1'b1;
					used_q <= used_base | (key_new ? (kscc_pkg::mask_t'(1) << key_idx) : '0);
					fill_q <= kscc_pkg::idx_t'(fill_base + kscc_pkg::idx_t'(key_new));
					if (key_new) begin
						fwd_q[fill_base] <= key_idx;
						inv_q[key_idx]   <= fill_base;
					end
				end
				kscc_pkg::MODE_FINISH: begin
					for (int i = 0; i < kscc_pkg::AlphaN; i++) begin
						fwd_q[i] <= fin_fwd[i];
						inv_q[i] <= fin_inv[i];
					end
					used_q <= '1;
					fill_q <= kscc_pkg::idx_t'(fill_q + unused_n);
					open_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/keyword_substitution_cipher_core.sv
// Keyword substitution cipher: keyword loading, table finish, encrypt and decrypt.
//
// The item channel carries a mode and a byte. Mode 0 feeds one keyword byte,
// mode 1 completes the table with the remaining letters in alphabetical order,
// mode 2 encrypts and mode 3 decrypts one byte. Modes 0 and 1 produce no result
// beat; modes 2 and 3 produce exactly one on the result channel, with the case
// of letters kept and non-letters passed through with was_letter low.
// Each accepted beat is captured in an input register, handled by one level
// of table logic, and a result is held in an output register. A result beat is
// loaded into the output register as its beat leaves the input register.
// While the result channel is not stalled, one item is accepted per cycle,
// including a table change followed directly by a cipher beat, which
// sees the updated table. The table update and lookup both sit between the
// input register and the output register.
// Reset is asynchronous: the tables return to identity, no table is open and
// both registers are emptied. When the receiver stalls, the result holds and
// the input register keeps taking keyword and finish beats, which pass on; the
// first beat that produces a result waits there and holds back all beats behind it.
module keyword_substitution_cipher_core (
	input logic        clk,
	input logic        arst_n,
	kscc_in_if.sink    item,
	kscc_out_if.source result
);

	logic            valid_s1;
	kscc_pkg::mode_t mode_s1;
	logic [7:0]      char_s1;

	logic            out_valid_q;
	logic [7:0]      out_char_q;
	logic            was_letter_q;

	logic            emits;
	logic            out_free;
	logic            adv;
	kscc_pkg::cmd_t  cmd;
	kscc_pkg::res_t  res;

	assign emits    = (mode_s1 == kscc_pkg::MODE_ENC) || (mode_s1 == kscc_pkg::MODE_DEC);
	assign out_free = !out_valid_q || result.ready;
	assign adv      = valid_s1 && (!emits || out_free);

	assign item.ready = !valid_s1 || adv;

	assign cmd.en      = adv;
	assign cmd.mode    = mode_s1;
	assign cmd.in_char = char_s1;

	kscc_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (out_free) begin
				out_valid_q <= adv && emits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_s1 <= kscc_pkg::mode_t'(item.mode);
			char_s1 <= item.in_char;
		end
		if (adv && emits) begin
			out_char_q   <= res.out_char;
			was_letter_q <= res.was_letter;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_char   = out_char_q;
	assign result.was_letter = was_letter_q;

endmodule

>>> rtl/kscc_checker.sv
// Port-level checks for the cipher core and the bind that attaches them.
module kscc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] out_char,
	input logic       was_letter
);

	logic out_is_letter;

	assign out_is_letter = kscc_pkg::is_lower(out_char) || kscc_pkg::is_upper(out_char);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(out_char) && $stable(was_letter))
		else $error("result payload changed while stalled");

	a_letter_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (was_letter == out_is_letter))
		else $error("letter flag does not match the result byte");

endmodule

bind keyword_substitution_cipher_core kscc_checker u_kscc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.out_char     (result.out_char),
	.was_letter   (result.was_letter)
);
